// ----- hdl/sssc_pkg.sv -----
// sssc_pkg: shared types, constants and fixed-point helpers of the selective scan
// holds the sequencer state type, exp2 and log2(1+z) tables, rounding and table lookup functions
// no dependencies
`default_nettype none

package sssc_pkg;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SP_Y,
    ST_SP_E,
    ST_SP_L,
    ST_SP_D,
    ST_DM,
    ST_Y_LO,
    ST_Y_HI,
    ST_Y_SUM,
    ST_DECAY,
    ST_H_MUL,
    ST_H_UPD,
    ST_T_MUL,
    ST_T_SUM,
    ST_TOTAL,
    ST_G_E,
    ST_DIV,
    ST_G_MUL,
    ST_P_LO,
    ST_P_HI,
    ST_OUT
  } sssc_state_t;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16   = 16'd45426;

  // 2^-f over f in sixteenths, Q1.15
  localparam logic [15:0] EXP2_TAB [17] = '{
    16'd32768, 16'd31379, 16'd30048, 16'd28774, 16'd27554, 16'd26386,
    16'd25268, 16'd24196, 16'd23170, 16'd22188, 16'd21247, 16'd20347,
    16'd19484, 16'd18658, 16'd17867, 16'd17109, 16'd16384
  };

  // log2(1+z) over z in sixteenths, Q1.15
  localparam logic [15:0] LOG2P1_TAB [17] = '{
    16'd0,     16'd2866,  16'd5568,  16'd8124,  16'd10549, 16'd12855,
    16'd15055, 16'd17156, 16'd19168, 16'd21098, 16'd22952, 16'd24736,
    16'd26455, 16'd28114, 16'd29717, 16'd31267, 16'd32768
  };

  // right shift with round half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  // base-2 exponent for exp(-a), a in Q.12: y = round(a*log2e) in Q.16
  function automatic logic [20:0] y_of_mag(input logic [16:0] a);
    logic [34:0] p;
    p = 35'(a) * 35'(LOG2E_Q16) + 35'd2048;
    return 21'(p >> 12);
  endfunction

  // 2^-y with y in Q.16, result Q1.15
  function automatic logic [15:0] exp_of_y(input logic [20:0] y);
    logic [4:0]  ip;
    logic [3:0]  k;
    logic [11:0] r;
    logic [15:0] a;
    logic [15:0] b;
    logic [24:0] p;
    logic [15:0] v;
    ip = y[20:16];
    k  = y[15:12];
    r  = y[11:0];
    a  = EXP2_TAB[k];
    b  = EXP2_TAB[{1'b0, k} + 5'd1];
    p  = 25'(a - b) * 25'(r) + 25'd2048;
    v  = a - 16'(p >> 12);
    if (ip[4]) return 16'd0;
    return v >> ip[3:0];
  endfunction

  // log2(1+z) with z in Q1.15
  function automatic logic [15:0] log2_1p(input logic [15:0] z);
    logic [4:0]  k;
    logic [10:0] r;
    logic [15:0] a;
    logic [15:0] b;
    logic [23:0] p;
    k = z[15:11];
    r = z[10:0];
    a = LOG2P1_TAB[k[3:0]];
    b = LOG2P1_TAB[{1'b0, k[3:0]} + 5'd1];
    p = 24'(b - a) * 24'(r) + 24'd1024;
    if (k[4]) return 16'd32768;
    return a + 16'(p >> 11);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/selective_state_space_scan.sv -----
// selective_state_space_scan: one channel and state slot of the selective scan per item
// hidden state in one synchronous ram, shared multipliers stepped by a sequencer
// depends on sssc_pkg
//
// an item is taken only in ST_IDLE, so the block does not take the next item until
// the last one is through; an item with last_slot also runs the skip term, the
// sigmoid reciprocal divider and the gated product, and its result is registered in
// ST_OUT and held in an output register while the next item runs
// reset: a clearing pass writes zero to all CHANNELS*STATE_SIZE ram entries,
// one per cycle, before in_tready first rises
`default_nettype none

module selective_state_space_scan #(
  parameter int CHANNELS   = 64,
  parameter int STATE_SIZE = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // channel[5:0], state_slot[9:6], ssm_input[25:10], step_raw[41:26],
  // decay_rate[57:42], b_value[73:58], c_value[89:74], skip_gain[105:90],
  // gate_raw[121:106], zero fill[127:122]
  input  wire logic [127:0] in_tdata,
  input  wire logic         in_tlast,   // last_slot
  input  wire logic         in_tuser,   // first_token
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_channel[5:0], gated_value[21:6], saturated[22], zero fill[23]
  output logic [23:0]       out_tdata
);
  import sssc_pkg::*;

  localparam int DEPTH = CHANNELS * STATE_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sssc_state_t state_r, state_nxt;

  // hidden state ram
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] mem_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic signed [31:0] mem_wd;
  logic               mem_re;
  logic [AW-1:0]      mem_ra;

  logic [AW-1:0] clr_cnt_r;

  // item fields
  logic               first_r, last_r, ok_r;
  logic [5:0]         ch_r;
  logic [3:0]         slot_r;
  logic [AW-1:0]      idx_r;
  logic signed [15:0] u_r, step_r, b_r, c_r, skip_r, gate_r;
  logic [15:0]        nrate_r;

  // datapath
  logic [20:0]        y_r;
  logic [15:0]        e_r, l_r, delta_r, decay_r;
  logic [31:0]        m_r;
  logic signed [32:0] db_r;
  logic signed [48:0] dbu_r;
  logic [30:0]        plo_r, phi_r;
  logic signed [47:0] pd_r, ct_r;
  logic signed [31:0] hn_r;
  logic signed [39:0] sum_r, sumx_r;
  logic signed [41:0] total_r;
  logic [16:0]        dv_r, rem_r;
  logic [15:0]        nlo_r, q_r;
  logic [3:0]         cnt_r;
  logic signed [17:0] g_r;
  logic signed [38:0] pl_r;
  logic signed [39:0] ph_r;
  logic               out_valid_r;
  logic [23:0]        out_data_r;

  // input decode
  logic               in_xfer;
  logic [5:0]         in_ch;
  logic [3:0]         in_slot;
  logic               in_ok;
  logic [31:0]        in_idx;
  logic signed [16:0] rate_x, step_x, gate_x;
  logic [16:0]        rate_neg;

  assign in_ch   = in_tdata[5:0];
  assign in_slot = in_tdata[9:6];
  assign in_ok   = (32'(in_ch) < 32'(CHANNELS)) && (32'(in_slot) < 32'(STATE_SIZE));
  assign in_idx  = 32'(in_ch) * 32'(STATE_SIZE) + 32'(in_slot);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign rate_x    = {in_tdata[57], in_tdata[57:42]};
  assign rate_neg  = 17'(-rate_x);
  assign step_x    = {step_r[15], step_r};
  assign gate_x    = {gate_r[15], gate_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ram ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  assign mem_re = in_xfer;
  assign mem_ra = in_ok ? in_idx[AW-1:0] : '0;

  // combinational results of the wider steps
  logic [16:0]        step_mag, gate_mag;
  logic [32:0]        ln_p;
  logic [45:0]        y_sum;
  logic signed [63:0] hn_w, sum_w, prod_w, v_w;
  logic signed [31:0] hn_sat;
  logic signed [39:0] sum_sat;
  logic [15:0]        e_gate;
  logic [16:0]        d_gate;
  logic [30:0]        n_gate;
  logic [17:0]        div_t;
  logic               div_ge;
  logic [15:0]        s_gate;
  logic [32:0]        mg_p;
  logic [16:0]        mg;
  logic               sat_w;
  logic [15:0]        v_sat;

  always_comb begin
    step_mag = step_x[16] ? 17'(-step_x) : 17'(step_x);
    gate_mag = gate_x[16] ? 17'(-gate_x) : 17'(gate_x);
    ln_p     = 33'(l_r) * 33'(LN2_Q16) + 33'd262144;
    y_sum    = (46'(phi_r) << 14) + 46'(plo_r) + 46'd8388608;

    // state update with saturation to 32 bits
    hn_w = rnd_shr(64'(pd_r), 15) + rnd_shr(64'(dbu_r), 12);
    if (hn_w > 64'sd2147483647) hn_sat = 32'sh7FFFFFFF;
    else if (hn_w < -64'sd2147483648) hn_sat = 32'sh80000000;
    else hn_sat = 32'(hn_w);

    // slot sum with saturation to 40 bits
    sum_w = ((slot_r == 4'd0) ? 64'sd0 : 64'(sum_r)) + rnd_shr(64'(ct_r), 12);
    if (sum_w > 64'sd549755813887) sum_sat = 40'sh7FFFFFFFFF;
    else if (sum_w < -64'sd549755813888) sum_sat = 40'sh8000000000;
    else sum_sat = 40'(sum_w);

    // sigmoid denominator and rounded dividend
    e_gate = exp_of_y(y_r);
    d_gate = 17'd32768 + 17'(e_gate);
    n_gate = 31'h40000000 + 31'(d_gate >> 1);

    // one restoring division step
    div_t  = {rem_r, nlo_r[15]};
    div_ge = div_t >= 18'(dv_r);

    // silu magnitude
    s_gate = gate_r[15] ? (16'd32768 - q_r) : q_r;
    mg_p   = 33'(gate_mag) * 33'(s_gate) + 33'd16384;
    mg     = 17'(mg_p >> 15);

    // gated product and output saturation
    prod_w = (64'(ph_r) <<< 20) + 64'(pl_r);
    v_w    = rnd_shr(prod_w, 24);
    sat_w  = (v_w > 64'sd32767) || (v_w < -64'sd32768);
    if (v_w > 64'sd32767) v_sat = 16'h7FFF;
    else if (v_w < -64'sd32768) v_sat = 16'h8000;
    else v_sat = 16'(v_w);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and ram write control
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_wa    = idx_r;
    mem_wd    = hn_sat;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
        if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE:  if (in_xfer) state_nxt = ST_SP_Y;
      ST_SP_Y:  state_nxt = ST_SP_E;
      ST_SP_E:  state_nxt = ST_SP_L;
      ST_SP_L:  state_nxt = ST_SP_D;
      ST_SP_D:  state_nxt = ST_DM;
      ST_DM:    state_nxt = ST_Y_LO;
      ST_Y_LO:  state_nxt = ST_Y_HI;
      ST_Y_HI:  state_nxt = ST_Y_SUM;
      ST_Y_SUM: state_nxt = ST_DECAY;
      ST_DECAY: state_nxt = ST_H_MUL;
      ST_H_MUL: state_nxt = ST_H_UPD;
      ST_H_UPD: begin
        mem_we    = ok_r;
        state_nxt = ST_T_MUL;
      end
      ST_T_MUL: state_nxt = ST_T_SUM;
      ST_T_SUM: state_nxt = last_r ? ST_TOTAL : ST_IDLE;
      ST_TOTAL: state_nxt = ST_G_E;
      ST_G_E:   state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == 4'd0) state_nxt = ST_G_MUL;
      ST_G_MUL: state_nxt = ST_P_LO;
      ST_P_LO:  state_nxt = ST_P_HI;
      ST_P_HI:  state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // control registers: clear counter, slot sum, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (state_r == ST_T_SUM) sum_r <= last_r ? 40'sd0 : sum_sat;
      if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          first_r <= in_tuser;
          last_r  <= in_tlast;
          ch_r    <= in_ch;
          slot_r  <= in_slot;
          ok_r    <= in_ok;
          idx_r   <= in_idx[AW-1:0];
          u_r     <= in_tdata[25:10];
          step_r  <= in_tdata[41:26];
          nrate_r <= (!rate_x[16] && rate_x != 17'sd0) ? 16'd0 : rate_neg[15:0];
          b_r     <= in_tdata[73:58];
          c_r     <= in_tdata[89:74];
          skip_r  <= in_tdata[105:90];
          gate_r  <= in_tdata[121:106];
        end
      end
      // softplus of the step size
      ST_SP_Y: y_r <= y_of_mag(step_mag);
      ST_SP_E: e_r <= exp_of_y(y_r);
      ST_SP_L: l_r <= log2_1p(e_r);
      ST_SP_D: delta_r <= (step_r[15] ? 16'd0 : 16'(step_r)) + 16'(ln_p >> 19);
      // decay exponent and input term
      ST_DM: begin
        m_r  <= 32'(delta_r) * 32'(nrate_r);
        db_r <= $signed({1'b0, delta_r}) * b_r;
      end
      ST_Y_LO: begin
        plo_r <= 31'(m_r[13:0]) * 31'(LOG2E_Q16);
        dbu_r <= db_r * u_r;
      end
      ST_Y_HI:  phi_r <= 31'(m_r[27:14]) * 31'(LOG2E_Q16);
      ST_Y_SUM: y_r <= 21'(y_sum >> 24);
      ST_DECAY: decay_r <= (m_r[31:28] != 4'd0) ? 16'd0 : exp_of_y(y_r);
      // hidden state update
      ST_H_MUL: pd_r <= $signed({1'b0, decay_r}) *
                        ((first_r || !ok_r) ? 32'sd0 : mem_q);
      ST_H_UPD: hn_r <= hn_sat;
      ST_T_MUL: ct_r <= c_r * hn_r;
      ST_T_SUM: sumx_r <= sum_sat;
      // skip term and gate exponent
      ST_TOTAL: begin
        total_r <= 42'(sumx_r) + 42'(skip_r) * 42'(u_r);
        y_r     <= y_of_mag(gate_mag);
      end
      ST_G_E: begin
        dv_r  <= d_gate;
        rem_r <= 17'(n_gate[30:16]);
        nlo_r <= n_gate[15:0];
        cnt_r <= 4'd15;
      end
      // sigmoid reciprocal, one quotient bit per cycle
      ST_DIV: begin
        rem_r <= div_ge ? 17'(div_t - 18'(dv_r)) : div_t[16:0];
        q_r   <= {q_r[14:0], div_ge};
        nlo_r <= {nlo_r[14:0], 1'b0};
        cnt_r <= cnt_r - 4'd1;
      end
      ST_G_MUL: g_r <= gate_r[15] ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
      ST_P_LO:  pl_r <= g_r * $signed({1'b0, total_r[19:0]});
      ST_P_HI:  ph_r <= g_r * $signed(total_r[41:20]);
      ST_OUT: begin
        if (!out_valid_r || out_tready) out_data_r <= {1'b0, sat_w, v_sat, ch_r};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/sssc_checker.sv -----
// sssc_checker: port-level checks of the selective scan top level
// bound to selective_state_space_scan; no package use
`default_nettype none

module sssc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: no input transfer on the cycle after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // reset starts the clearing pass with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or valid right after reset");

endmodule

bind selective_state_space_scan sssc_checker u_sssc_checker (.*);

`default_nettype wire

// ----- dv/selective_state_space_scan_tb.sv -----
// selective_state_space_scan_tb: self-checking bench for the selective scan block
// drives slot sequences through the input stream and checks each gated result
// depends on selective_state_space_scan
`timescale 1ns / 1ps

module selective_state_space_scan_tb;

  localparam int CHANNELS   = 64;
  localparam int STATE_SIZE = 16;
  localparam int NUM_RANDOM = 395;
  localparam int CYCLE_LIMIT = 400000;

  // one scan item as the bench sees it
  typedef struct {
    logic              first_token;
    logic [5:0]        channel;
    logic [3:0]        state_slot;
    logic              last_slot;
    logic signed [15:0] ssm_input;
    logic signed [15:0] step_raw;
    logic signed [15:0] decay_rate;
    logic signed [15:0] b_value;
    logic signed [15:0] c_value;
    logic signed [15:0] skip_gain;
    logic signed [15:0] gate_raw;
  } scan_item_t;

  typedef struct {
    logic [5:0]  channel;
    logic [15:0] gated;
    logic        sat;
  } gated_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;

  selective_state_space_scan #(.CHANNELS(CHANNELS), .STATE_SIZE(STATE_SIZE)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  scan_item_t    pending_items[$];
  gated_result_t expected_results[$];
  logic signed [31:0] hidden_mirror [CHANNELS*STATE_SIZE];
  logic signed [63:0] running_sum;
  int  error_count = 0;
  int  result_count = 0;
  int  cycle_count = 0;
  bit  stimulus_done = 1'b0;
  bit  quiet_mode = 1'b0;
  bit  hold_request = 1'b0;

  localparam logic [15:0] EXP2_LUT [17] = '{
    16'd32768, 16'd31379, 16'd30048, 16'd28774, 16'd27554, 16'd26386,
    16'd25268, 16'd24196, 16'd23170, 16'd22188, 16'd21247, 16'd20347,
    16'd19484, 16'd18658, 16'd17867, 16'd17109, 16'd16384
  };
  localparam logic [15:0] LOG2P1_LUT [17] = '{
    16'd0,     16'd2866,  16'd5568,  16'd8124,  16'd10549, 16'd12855,
    16'd15055, 16'd17156, 16'd19168, 16'd21098, 16'd22952, 16'd24736,
    16'd26455, 16'd28114, 16'd29717, 16'd31267, 16'd32768
  };

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // rounding shift, halves away from zero
  function automatic longint round_shift(input longint v, input int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  // exp(-m), m in Q.24, result Q1.15
  function automatic longint decay_exp(input longint unsigned m);
    longint unsigned y, ip;
    longint unsigned f, k, r, a, b, v;
    y = (m * 64'd94548 + (64'd1 << 23)) >> 24;
    ip = y >> 16;
    if (ip >= 16) return 0;
    f = y & 64'hFFFF;
    k = f >> 12;
    r = f & 64'hFFF;
    a = EXP2_LUT[k];
    b = EXP2_LUT[k + 1];
    v = a - (((a - b) * r + 2048) >> 12);
    return longint'(v >> ip);
  endfunction

  function automatic longint log2_one_plus(input longint unsigned z);
    longint unsigned k, r, a, b;
    k = z >> 11;
    if (k >= 16) return 32768;
    r = z & 64'h7FF;
    a = LOG2P1_LUT[k];
    b = LOG2P1_LUT[k + 1];
    return longint'(a + (((b - a) * r + 1024) >> 11));
  endfunction

  function automatic longint softplus_step(input longint x);
    longint unsigned a, l, ln12;
    a = (x < 0) ? -x : x;
    l = log2_one_plus(decay_exp(a << 12));
    ln12 = (l * 64'd45426 + (64'd1 << 18)) >> 19;
    return ((x > 0) ? x : 0) + longint'(ln12);
  endfunction

  function automatic longint silu_gate(input longint x);
    longint unsigned a, d, s, m;
    a = (x < 0) ? -x : x;
    d = 32768 + decay_exp(a << 12);
    s = ((64'd1 << 30) + d / 2) / d;
    if (x < 0) s = 32768 - s;
    m = (a * s + (64'd1 << 14)) >> 15;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  // advance the mirrored scan state by one item, queue a result on last slot
  task automatic predict_scan(input scan_item_t it);
    longint rate, delta, decay, prev, hn, term, sum, total, g, v;
    int idx;
    gated_result_t res;
    idx = it.channel * STATE_SIZE + it.state_slot;
    rate = it.decay_rate;
    if (rate > 0) rate = 0;
    delta = softplus_step(it.step_raw);
    decay = decay_exp(longint'(delta) * (-rate));
    prev = it.first_token ? 0 : hidden_mirror[idx];
    hn = round_shift(decay * prev, 15)
       + round_shift(delta * longint'(it.b_value) * longint'(it.ssm_input), 12);
    if (hn > 64'sh7FFFFFFF) hn = 64'sh7FFFFFFF;
    if (hn < -64'sh80000000) hn = -64'sh80000000;
    hidden_mirror[idx] = 32'(hn);
    term = round_shift(longint'(it.c_value) * hn, 12);
    sum = ((it.state_slot == 0) ? 0 : running_sum) + term;
    if (sum > (longint'(1) <<< 39) - 1) sum = (longint'(1) <<< 39) - 1;
    if (sum < -(longint'(1) <<< 39)) sum = -(longint'(1) <<< 39);
    if (!it.last_slot) begin
      running_sum = sum;
      return;
    end
    running_sum = 0;
    total = sum + longint'(it.skip_gain) * longint'(it.ssm_input);
    g = silu_gate(it.gate_raw);
    v = round_shift(g * total, 24);
    res.sat = 1'b0;
    if (v > 32767) begin
      v = 32767;
      res.sat = 1'b1;
    end else if (v < -32768) begin
      v = -32768;
      res.sat = 1'b1;
    end
    res.channel = it.channel;
    res.gated = v[15:0];
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, result_count);
    error_count++;
  endtask

  function automatic logic signed [15:0] rand_q12();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 8192)) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic scan_item_t random_item(input logic [5:0] ch, input logic [3:0] slot,
                                             input logic last, input logic first);
    scan_item_t it;
    it.first_token = first;
    it.channel = ch;
    it.state_slot = slot;
    it.last_slot = last;
    it.ssm_input = rand_q12();
    it.step_raw = rand_q12();
    // mostly valid negative rates, sometimes positive ones
    it.decay_rate = ($urandom_range(0, 7) == 0) ? rand_q12()
                    : -16'sh0001 * 16'($urandom_range(0, 32768));
    it.b_value = rand_q12();
    it.c_value = rand_q12();
    it.skip_gain = rand_q12();
    it.gate_raw = rand_q12();
    return it;
  endfunction

  // stimulus
  initial begin
    scan_item_t it;
    int n, len, ch;
    // mirrored state starts cleared, as after reset
    foreach (hidden_mirror[i]) hidden_mirror[i] = '0;
    running_sum = '0;
    n = 0;
    // directed: full-scale fields on one short token, both first_token values
    it = random_item(6'd0, 4'd0, 1'b0, 1'b1);
    it.ssm_input = 16'sh7FFF; it.step_raw = 16'sh7FFF; it.decay_rate = 16'sh8000;
    it.b_value = 16'sh7FFF; it.c_value = 16'sh7FFF;
    pending_items.push_back(it);
    it = random_item(6'd0, 4'd1, 1'b1, 1'b0);
    it.ssm_input = 16'sh8000; it.step_raw = 16'sh8000; it.decay_rate = 16'sh0000;
    it.skip_gain = 16'sh7FFF; it.gate_raw = 16'sh7FFF;
    pending_items.push_back(it);
    // saturating result and large negative gate
    it = random_item(6'd63, 4'd15, 1'b1, 1'b0);
    it.ssm_input = 16'sh7FFF; it.skip_gain = 16'sh7FFF; it.gate_raw = 16'sh7FFF;
    pending_items.push_back(it);
    it = random_item(6'd63, 4'd0, 1'b1, 1'b1);
    it.ssm_input = 16'sh8000; it.skip_gain = 16'sh7FFF; it.gate_raw = 16'sh8000;
    pending_items.push_back(it);
    // positive decay rate, slot zero restarting a leftover sum
    it = random_item(6'd5, 4'd0, 1'b0, 1'b0);
    it.decay_rate = 16'sh7FFF;
    pending_items.push_back(it);
    it = random_item(6'd5, 4'd1, 1'b0, 1'b0);
    pending_items.push_back(it);
    it = random_item(6'd5, 4'd0, 1'b1, 1'b0);
    pending_items.push_back(it);
    // state slot runs repeated so hidden state builds up
    for (int t = 0; t < 3; t++) begin
      for (int s = 0; s < 16; s++) begin
        it = random_item(6'd9, 4'(s), s == 15, t == 0);
        it.b_value = 16'sh7FFF; it.ssm_input = 16'sh7FFF; it.step_raw = 16'sh7FFF;
        it.decay_rate = 16'sh0000; it.c_value = 16'sh7FFF;
        pending_items.push_back(it);
      end
    end
    // random: mostly whole tokens, some broken runs
    while (n < NUM_RANDOM) begin
      ch = $urandom_range(0, 63);
      if ($urandom_range(0, 9) == 0) begin
        it = random_item(6'(ch), 4'($urandom), 1'($urandom), 1'($urandom));
        pending_items.push_back(it);
        n++;
      end else begin
        len = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 6);
        for (int s = 0; s < len; s++) begin
          pending_items.push_back(random_item(6'(ch), 4'(s), s == len - 1,
                                              $urandom_range(0, 5) == 0));
          n++;
        end
      end
    end
  end

  // reset, then hold off the receiver once, then wait for drain
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_items.size() < 200);
    hold_request = 1'b1;
    repeat (400) @(posedge clk);
    hold_request = 1'b0;
    wait (pending_items.size() < 40);
    quiet_mode = 1'b1;
    wait (pending_items.size() == 0 && !in_tvalid);
    stimulus_done = 1'b1;
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    $display("Ran %0d gated results across random slot runs, broken runs and a long stall.",
             result_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // note whether the current item was taken at the last rising edge
  logic in_tready_seen = 1'b0;
  always @(posedge clk) begin
    in_tready_seen <= in_tvalid && in_tready;
  end

  // input driver
  int in_gap = 0;
  always @(negedge clk) begin
    scan_item_t it;
    if (rst_n && (!in_tvalid || in_tready_seen)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(1, 13);
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        predict_scan(it);
        in_tdata <= {6'd0, it.gate_raw, it.skip_gain, it.c_value, it.b_value,
                     it.decay_rate, it.step_raw, it.ssm_input, it.state_slot, it.channel};
        in_tlast <= it.last_slot;
        in_tuser <= it.first_token;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  int out_gap = 0;
  always @(negedge clk) begin
    if (hold_request) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      out_gap <= $urandom_range(1, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor and cycle limit
  always @(posedge clk) begin
    gated_result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      result_count <= result_count + 1;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[5:0] !== want.channel)
          report_mismatch("out_channel", out_tdata[5:0], want.channel);
        if (out_tdata[21:6] !== want.gated)
          report_mismatch("gated_value", $signed(out_tdata[21:6]), $signed(want.gated));
        if (out_tdata[22] !== want.sat)
          report_mismatch("saturated", out_tdata[22], want.sat);
      end
    end
  end

endmodule
